// ===== design/trajectory_moving_average_smoother_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trajectory smoother
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_MOVING_AVERAGE_SMOOTHER_DEFINES_SVH
`define TRAJECTORY_MOVING_AVERAGE_SMOOTHER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TMAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tmas assertion failed");
// next-cycle implication
`define TMAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tmas assertion failed");
`else
`define TMAS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TMAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/tmas_pkg.sv =====
// ----------------------------------------------------------------------------
// tmas_pkg
// Shared widths, job and status types, and helpers for the smoother.
// ----------------------------------------------------------------------------
package tmas_pkg;

	localparam int DATA_W    = 32;
	localparam int N_CH      = 3;
	localparam int PATH_W    = 48;
	localparam int WIN_DEPTH = 64;
	localparam int WIN_AW    = 6;
	localparam int RAD_W     = 5;
	localparam int K_W       = 10;
	localparam int SUM_W     = 54;   // 63 path values of 48 bits
	localparam int CNT_W     = 6;    // window count up to 63
	localparam int DIFF_W    = 56;
	localparam int STEP_W    = 6;

	localparam logic [RAD_W-1:0] RAD_RESET  = 5'd30;
	localparam logic [RAD_W-1:0] MAX_RADIUS = 5'd31;
	localparam logic [RAD_W-1:0] RAD_LIMIT  = RAD_W'((WIN_DEPTH - 2) / 2);
	localparam logic [K_W-1:0]   K_MAX      = 10'd1000;
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);

	// one accepted frame, handed from front to back
	typedef struct packed {
		logic [K_W-1:0]    k;       // index of the newest frame, clamped
		logic              final_f; // stream ends with this frame
		logic [RAD_W-1:0]  r;       // radius latched for the stream
		logic [WIN_AW-1:0] wslot;   // window slot of the newest frame
	} job_t;

	typedef struct packed {
		logic idle;
	} back_stat_t;

	typedef enum logic [2:0] {
		B_IDLE, B_SETUP, B_SUM, B_PREV, B_PLAT, B_DIV, B_FIN, B_OUT
	} back_state_t;

	// radius clamp applied when a stream starts
	function automatic logic [RAD_W-1:0] rad_clamp(input logic [RAD_W-1:0] v);
		logic [RAD_W-1:0] t;
		t = (v > MAX_RADIUS) ? MAX_RADIUS : v;
		return (t > RAD_LIMIT) ? RAD_LIMIT : t;
	endfunction

	// saturate a wide signed value to 32 bits
	function automatic logic [DATA_W-1:0] sat32(input logic signed [DIFF_W-1:0] v);
		logic fits;
		fits = (&v[DIFF_W-1:DATA_W-1]) || !(|v[DIFF_W-1:DATA_W-1]);
		if (fits) return v[DATA_W-1:0];
		return v[DIFF_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

endpackage

// ===== design/tmas_ram.sv =====
// ----------------------------------------------------------------------------
// tmas_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/tmas_front.sv =====
// ----------------------------------------------------------------------------
// tmas_front
// Accepts frames, accumulates the saturated path, writes the window memory
// and issues one job per frame. Holds the radius register.
// ----------------------------------------------------------------------------
module tmas_front (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [tmas_pkg::RAD_W-1:0]                   cfg_data,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	input  logic [tmas_pkg::N_CH*tmas_pkg::DATA_W-1:0]   s_tdata,
	input  logic                                         s_tlast,
	input  logic                                         q_full,
	input  tmas_pkg::back_stat_t                         stat,
	output logic                                         push,
	output tmas_pkg::job_t                               job,
	output logic                                         ram_we,
	output logic [tmas_pkg::WIN_AW-1:0]                  ram_waddr,
	output logic [tmas_pkg::N_CH*tmas_pkg::PATH_W-1:0]   ram_wdata
);
	import tmas_pkg::*;

	logic [RAD_W-1:0]         radius_q;
	logic [RAD_W-1:0]         r_q;
	logic [WIN_AW-1:0]        ws_q;
	logic [31:0]              fc_q;
	logic signed [PATH_W-1:0] path_q [N_CH];
	logic signed [PATH_W-1:0] path_n [N_CH];
	logic                     acc;
	logic                     first;
	logic [WIN_AW-1:0]        ws_n;
	logic [RAD_W-1:0]         r_n;

	// config register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_RESET;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	// a new stream waits for the back to drain the old one (window slots reuse)
	assign s_tready = !q_full && ((fc_q != 32'd0) || stat.idle);
	assign acc      = s_tvalid && s_tready;
	assign first    = (fc_q == 32'd0);
	assign ws_n     = first ? '0 : ws_q + 1'b1;
	assign r_n      = first ? rad_clamp(radius_q) : r_q;

	// saturating path accumulation
	always_comb begin
		logic signed [PATH_W:0] s;
		for (int c = 0; c < N_CH; c++) begin
			s = {path_q[c][PATH_W-1], path_q[c]}
				+ {{(PATH_W-DATA_W+1){s_tdata[c*DATA_W+DATA_W-1]}},
				   s_tdata[c*DATA_W +: DATA_W]};
			if (s[PATH_W] != s[PATH_W-1]) begin
				path_n[c] = s[PATH_W] ? {1'b1, {(PATH_W-1){1'b0}}}
				                      : {1'b0, {(PATH_W-1){1'b1}}};
			end else begin
				path_n[c] = s[PATH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
			ws_q <= '0;
			r_q  <= '0;
			for (int c = 0; c < N_CH; c++) path_q[c] <= '0;
		end else if (acc) begin
			r_q <= r_n;
			if (s_tlast) begin
				fc_q <= '0;
				ws_q <= '0;
				for (int c = 0; c < N_CH; c++) path_q[c] <= '0;
			end else begin
				ws_q <= ws_n;
				if (fc_q != 32'hffff_ffff) fc_q <= fc_q + 32'd1;
				for (int c = 0; c < N_CH; c++) path_q[c] <= path_n[c];
			end
		end
	end

	// window write and job issue
	assign ram_we    = acc;
	assign ram_waddr = ws_n;
	assign ram_wdata = {path_n[2], path_n[1], path_n[0]};
	assign push      = acc;
	assign job.k       = (fc_q > {22'd0, K_MAX}) ? K_MAX : fc_q[K_W-1:0];
	assign job.final_f = s_tlast;
	assign job.r       = r_n;
	assign job.wslot   = ws_n;

endmodule

// ===== design/tmas_jobq.sv =====
// ----------------------------------------------------------------------------
// tmas_jobq
// Single-entry job queue between front and back.
// ----------------------------------------------------------------------------
module tmas_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tmas_pkg::job_t job_in,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output tmas_pkg::job_t job_out
);
	import tmas_pkg::*;

	logic valid_q;
	job_t job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) job_q <= job_in;
	end

	assign full    = valid_q;
	assign valid   = valid_q;
	assign job_out = job_q;

endmodule

// ===== design/tmas_back.sv =====
// ----------------------------------------------------------------------------
// tmas_back
// Per result: sums the window over the memory port, reads the previous
// path, divides by the window count with rounding, saturates and emits.
// ----------------------------------------------------------------------------
module tmas_back (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_valid,
	input  tmas_pkg::job_t                             q_job,
	output logic                                       q_pop,
	output tmas_pkg::back_stat_t                       stat,
	output logic [tmas_pkg::WIN_AW-1:0]                ram_raddr,
	input  logic [tmas_pkg::N_CH*tmas_pkg::PATH_W-1:0] ram_rdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	output logic [tmas_pkg::N_CH*tmas_pkg::DATA_W-1:0] m_tdata,
	output logic                                       m_tlast
);
	import tmas_pkg::*;

	back_state_t             state_q, state_n;
	job_t                    job_q;
	logic [WIN_AW-1:0]       b_q, lo_q, hi_q, idx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    has_prev_q;
	logic                    pend_s1;
	logic [STEP_W-1:0]       step_q;
	logic signed [SUM_W-1:0] sum_q  [N_CH];
	logic signed [PATH_W-1:0] prev_q [N_CH];
	logic [SUM_W-1:0]        quo_q  [N_CH];
	logic [CNT_W-1:0]        rem_q  [N_CH];
	logic                    neg_q  [N_CH];
	logic [DATA_W-1:0]       out_q  [N_CH];
	logic                    last_q;
	logic                    take;
	logic [WIN_AW-1:0]       b_first;
	logic [WIN_AW:0]         b_plus_r;
	logic [WIN_AW-1:0]       b_inc;

	assign take     = q_valid && (q_job.final_f || q_job.k >= {5'd0, q_job.r});
	assign b_first  = !q_job.final_f ? {1'b0, q_job.r}
	                : (q_job.k < {5'd0, q_job.r}) ? q_job.k[WIN_AW-1:0] : {1'b0, q_job.r};
	assign b_plus_r = {1'b0, b_q} + {2'b0, job_q.r};
	assign b_inc    = b_q + 1'b1;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			B_IDLE:  if (take) state_n = B_SETUP;
			B_SETUP: state_n = B_SUM;
			B_SUM:   if (idx_q == hi_q) state_n = B_PREV;
			B_PREV:  state_n = B_PLAT;
			B_PLAT:  state_n = B_DIV;
			B_DIV:   if (step_q == DIV_LAST) state_n = B_FIN;
			B_FIN:   state_n = B_OUT;
			B_OUT: begin
				if (m_tready) state_n = (job_q.final_f && b_q != '0) ? B_SETUP : B_IDLE;
			end
			default: state_n = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop           = (state_q == B_IDLE) && q_valid;
		m_tvalid        = (state_q == B_OUT);
		stat.idle       = (state_q == B_IDLE);
		unique case (state_q)
			B_PREV:  ram_raddr = job_q.wslot - b_inc;
			default: ram_raddr = job_q.wslot - idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_n;
			pend_s1 <= (state_q == B_SUM);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		logic [CNT_W:0] r2;
		logic signed [SUM_W:0]  avg;
		logic [SUM_W-1:0]       mag;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					job_q <= q_job;
					b_q   <= b_first;
				end
			end
			B_SETUP: begin
				lo_q       <= (b_q > {1'b0, job_q.r}) ? b_q - {1'b0, job_q.r} : '0;
				hi_q       <= (b_plus_r > job_q.k[WIN_AW:0] && job_q.k < 10'd64)
				              ? job_q.k[WIN_AW-1:0] : b_plus_r[WIN_AW-1:0];
				idx_q      <= (b_q > {1'b0, job_q.r}) ? b_q - {1'b0, job_q.r} : '0;
				has_prev_q <= ({4'd0, b_inc} <= job_q.k) && (b_q != '1);
				for (int c = 0; c < N_CH; c++) sum_q[c] <= '0;
			end
			B_SUM: begin
				idx_q <= idx_q + 1'b1;
				cnt_q <= hi_q - lo_q + 1'b1;
			end
			B_PLAT: begin
				step_q <= '0;
				for (int c = 0; c < N_CH; c++) begin
					prev_q[c] <= has_prev_q ? ram_rdata[c*PATH_W +: PATH_W] : '0;
					neg_q[c]  <= sum_q[c][SUM_W-1];
					mag = sum_q[c][SUM_W-1] ? SUM_W'(-sum_q[c]) : SUM_W'(sum_q[c]);
					quo_q[c]  <= mag + SUM_W'(cnt_q >> 1);
					rem_q[c]  <= '0;
				end
			end
			B_DIV: begin
				step_q <= step_q + 1'b1;
				for (int c = 0; c < N_CH; c++) begin
					r2 = {rem_q[c], quo_q[c][SUM_W-1]};
					if (r2 >= {1'b0, cnt_q}) begin
						rem_q[c] <= CNT_W'(r2 - {1'b0, cnt_q});
						quo_q[c] <= {quo_q[c][SUM_W-2:0], 1'b1};
					end else begin
						rem_q[c] <= r2[CNT_W-1:0];
						quo_q[c] <= {quo_q[c][SUM_W-2:0], 1'b0};
					end
				end
			end
			B_FIN: begin
				last_q <= job_q.final_f && (b_q == '0);
				for (int c = 0; c < N_CH; c++) begin
					avg = neg_q[c] ? -$signed({1'b0, quo_q[c]}) : $signed({1'b0, quo_q[c]});
					out_q[c] <= sat32(DIFF_W'(avg) - DIFF_W'(prev_q[c]));
				end
			end
			B_OUT: begin
				if (m_tready && b_q != '0) b_q <= b_q - 1'b1;
			end
			default: ;
		endcase
		// window data arrives in the cycle after its address
		if (pend_s1) begin
			for (int c = 0; c < N_CH; c++) begin
				sum_q[c] <= sum_q[c] + SUM_W'($signed(ram_rdata[c*PATH_W +: PATH_W]));
			end
		end
	end

	assign m_tdata = {out_q[2], out_q[1], out_q[0]};
	assign m_tlast = last_q;

endmodule

// ===== design/trajectory_moving_average_smoother.sv =====
// ----------------------------------------------------------------------------
// trajectory_moving_average_smoother
// Usage:
//   s_t* carries one frame motion per transaction (tdata: motion_x,
//   motion_y, motion_angle, each signed Q16.16; tlast: final_frame).
//   m_t* carries one corrected motion per transaction (tdata: corrected_x,
//   corrected_y, corrected_angle; tlast: last_result).
//   cfg_* writes the averaging radius R; it is latched at the first frame
//   of each stream.
//   Results trail the input by R frames; the final frame flushes up to
//   R+1 results. The time to each result, and to each further flush result,
//   is set by the window sum (one memory read per cycle) and the 54-step
//   serial divider.
//   One frame may be queued while the back end works; the first frame of a
//   new stream waits until the previous stream is fully delivered.
//   Reset clears the path, frame count and queue; the radius returns to 30.
//   A stalled m_tready holds the result and, once the queue is full, s_tready.
// ----------------------------------------------------------------------------
`include "trajectory_moving_average_smoother_defines.svh"

module trajectory_moving_average_smoother (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [tmas_pkg::RAD_W-1:0]                 cfg_data,  // averaging radius
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// motion_x, motion_y, motion_angle
	input  logic [tmas_pkg::N_CH*tmas_pkg::DATA_W-1:0] s_tdata,
	input  logic                                       s_tlast,   // final_frame
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// corrected_x, corrected_y, corrected_angle
	output logic [tmas_pkg::N_CH*tmas_pkg::DATA_W-1:0] m_tdata,
	output logic                                       m_tlast    // last_result
);
	import tmas_pkg::*;

	logic                        push, q_full, q_valid, q_pop;
	job_t                        job_in, job_out;
	back_stat_t                  stat;
	logic                        ram_we;
	logic [WIN_AW-1:0]           ram_waddr, ram_raddr;
	logic [N_CH*PATH_W-1:0]      ram_wdata, ram_rdata;

	tmas_front u_front (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.q_full, .stat, .push, .job(job_in),
		.ram_we, .ram_waddr, .ram_wdata
	);

	tmas_jobq u_jobq (
		.clk, .arst_n, .push, .job_in, .full(q_full),
		.pop(q_pop), .valid(q_valid), .job_out
	);

	tmas_ram #(.WIDTH(N_CH*PATH_W), .DEPTH(WIN_DEPTH)) u_win (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	tmas_back u_back (
		.clk, .arst_n, .q_valid, .q_job(job_out), .q_pop, .stat,
		.ram_raddr, .ram_rdata, .m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

	// checks
	`TMAS_ASSERT_NEXT(a_accept_queues, clk, arst_n, s_tvalid && s_tready, q_valid)
	`TMAS_ASSERT_IMPL(a_no_overrun, clk, arst_n, push, !q_full)
	`TMAS_ASSERT_IMPL(a_out_busy, clk, arst_n, m_tvalid, !stat.idle)

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Trajectory smoother testbench
// Streams frame motions through the smoother under several radius settings
// and idle/stall mixes, predicts every corrected motion from a behavioral
// copy of the path window and average, and checks results in order.
// ----------------------------------------------------------------------------

class traj_scoreboard;
	// behavioral state of the smoother
	logic [4:0] radius_reg;
	logic [4:0] radius_run;
	longint path_win[3][64];
	longint path_sum[3];
	int unsigned frames;
	int unsigned wslot;
	// expected corrected motions, oldest first
	logic [96:0] pending[$];
	int errors;
	int results_seen;

	function void clear();
		radius_reg = 5'd30;
		radius_run = '0;
		path_sum = '{0, 0, 0};
		frames = 0;
		wslot = 0;
		pending.delete();
		errors = 0;
		results_seen = 0;
	endfunction

	function longint rounded_avg(longint total, int unsigned cnt);
		longint mag;
		longint q;
		mag = (total < 0) ? -total : total;
		q = (mag + cnt / 2) / cnt;
		return (total < 0) ? -q : q;
	endfunction

	function logic [31:0] clip32(longint v);
		if (v > 64'sh7fffffff) return 32'h7fffffff;
		if (v < -64'sh80000000) return 32'h80000000;
		return v[31:0];
	endfunction

	function int unsigned slot_of(int unsigned back);
		return (wslot + 64 - (back % 64)) % 64;
	endfunction

	function void push_result(int unsigned back, int unsigned k, logic last);
		int unsigned hi;
		int unsigned lo;
		longint total;
		longint prev;
		logic [96:0] res;
		hi = (back + radius_run > k) ? k : back + radius_run;
		lo = (back > radius_run) ? back - radius_run : 0;
		for (int c = 0; c < 3; c++) begin
			total = 0;
			prev = 0;
			for (int unsigned b = lo; b <= hi; b++)
				total += path_win[c][slot_of(b)];
			if (back + 1 <= k)
				prev = path_win[c][slot_of(back + 1)];
			res[c*32 +: 32] = clip32(rounded_avg(total, hi - lo + 1) - prev);
		end
		res[96] = last;
		pending = {pending, res};
	endfunction

	// accepted frame: update path and queue the results it releases
	function void note_frame(logic [95:0] motion, logic final_f);
		int unsigned k;
		int unsigned b;
		longint p;
		if (frames == 0) begin
			// radius limit is 31, the full range of the register
			radius_run = radius_reg;
			wslot = 0;
		end else begin
			wslot = (wslot + 1) % 64;
		end
		for (int c = 0; c < 3; c++) begin
			p = path_sum[c] + longint'($signed(motion[c*32 +: 32]));
			if (p > 64'sh7fffffffffff) p = 64'sh7fffffffffff;
			if (p < -64'sh800000000000) p = -64'sh800000000000;
			path_sum[c] = p;
			path_win[c][wslot] = p;
		end
		k = (frames > 1000) ? 1000 : frames;
		if (frames != 32'hffffffff) frames++;
		if (!final_f) begin
			if (k >= radius_run) push_result(radius_run, k, 1'b0);
		end else begin
			b = (k < radius_run) ? k : radius_run;
			forever begin
				push_result(b, k, b == 0);
				if (b == 0) break;
				b--;
			end
			path_sum = '{0, 0, 0};
			frames = 0;
			wslot = 0;
		end
	endfunction

	// accepted result: compare against the oldest expectation
	function void check_result(logic [95:0] data, logic last);
		logic [96:0] exp_r;
		results_seen++;
		if (pending.size() == 0) begin
			$error("unexpected result %h last=%0b", data, last);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (data[31:0] !== exp_r[31:0]) begin
			$error("corrected_x exp %h got %h", exp_r[31:0], data[31:0]);
			errors++;
		end
		if (data[63:32] !== exp_r[63:32]) begin
			$error("corrected_y exp %h got %h", exp_r[63:32], data[63:32]);
			errors++;
		end
		if (data[95:64] !== exp_r[95:64]) begin
			$error("corrected_angle exp %h got %h", exp_r[95:64], data[95:64]);
			errors++;
		end
		if (last !== exp_r[96]) begin
			$error("last_result exp %0b got %0b", exp_r[96], last);
			errors++;
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [4:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [95:0] s_tdata;   // motion_x, motion_y, motion_angle
	logic s_tlast;          // final_frame
	logic m_tvalid;
	logic m_tready;
	logic [95:0] m_tdata;   // corrected_x, corrected_y, corrected_angle
	logic m_tlast;          // last_result

	traj_scoreboard motion_board;
	int send_idle_pct;
	int recv_stall_pct;
	int frames_sent;
	int streams_sent;

	trajectory_moving_average_smoother dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, check every accepted transaction
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				motion_board.check_result(m_tdata, m_tlast);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic write_radius(input logic [4:0] r);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		motion_board.radius_reg = r;
		cfg_valid <= 1'b0;
	endtask

	// tvalid stays high after a transaction unless an idle cycle or a drain follows
	task automatic send_frame(input logic [95:0] motion, input logic final_f);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= motion;
		s_tlast <= final_f;
		do @(posedge clk); while (!s_tready);
		motion_board.note_frame(motion, final_f);
		frames_sent++;
		if (final_f) streams_sent++;
	endtask

	// wait for every expected result, then settle before touching config
	task automatic drain();
		s_tvalid <= 1'b0;
		while (motion_board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_motion();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom();
			default: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
		endcase
	endfunction

	task automatic send_stream(input int len);
		for (int i = 0; i < len; i++)
			send_frame({rand_motion(), rand_motion(), rand_motion()}, i == len - 1);
	endtask

	initial begin
		logic [4:0] radius_plan[6];
		int idle_plan[4];
		int stall_plan[4];
		int len;
		motion_board = new();
		motion_board.clear();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		frames_sent = 0;
		streams_sent = 0;
		radius_plan = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd30, 5'd7};
		idle_plan = '{0, 57, 0, 20};
		stall_plan = '{0, 0, 57, 20};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset radius, extreme motions, single-frame stream
		for (int i = 0; i < 8; i++)
			send_frame({32'h7fffffff, 32'h80000000, (i[0] ? 32'h7fffffff : 32'h0)}, 1'b0);
		send_frame({32'h80000000, 32'h7fffffff, 32'hffffffff}, 1'b1);
		send_frame({32'h00010000, 32'hffff0000, 32'h00008000}, 1'b1);
		drain();
		// directed: radius 2, exact rounding ties
		write_radius(5'd2);
		send_frame({32'd1, 32'hffffffff, 32'd2}, 1'b0);
		send_frame({32'd0, 32'd0, 32'd1}, 1'b0);
		send_frame({32'd3, 32'hfffffffd, 32'd0}, 1'b0);
		send_frame({32'd1, 32'd0, 32'hffffffff}, 1'b0);
		send_frame({32'd2, 32'd1, 32'd1}, 1'b0);
		send_frame({32'd0, 32'd0, 32'd0}, 1'b1);
		drain();

		// random: phases of idling, several radii, short streams; one long
		// stream wraps the window
		for (int ph = 0; ph < 6; ph++) begin
			write_radius(radius_plan[ph]);
			send_idle_pct = idle_plan[ph % 4];
			recv_stall_pct = stall_plan[ph % 4];
			for (int s = 0; s < 2; s++) begin
				len = (ph == 3 && s == 0) ? 66 : $urandom_range(1, 4);
				send_stream(len);
			end
			drain();
		end
		recv_stall_pct = 0;
		drain();

		$display("covered %0d frames in %0d streams, %0d results checked",
			frames_sent, streams_sent, motion_board.results_seen);
		if (motion_board.errors == 0 && motion_board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
